/* rtl/core/triangle_bisection_index_generator_assert.svh */
// Assertion macros for the triangle bisection index generator.
// No dependencies; included by RTL files that carry assertions.
`ifndef TRIANGLE_BISECTION_INDEX_GENERATOR_ASSERT_SVH
`define TRIANGLE_BISECTION_INDEX_GENERATOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TBIG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbig assertion failed: same-cycle check");
// next-cycle implication
`define TBIG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbig assertion failed: next-cycle check");
`else
`define TBIG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TBIG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/tbig_pkg.sv */
// Package for the triangle bisection index generator: widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbig_pkg;

    localparam int VTX_W   = 16;  // vertex field width
    localparam int LEVEL_W = 3;   // level / depth width
    localparam int ERR_W   = 2;
    localparam int CFG_A_W = 2;   // register index width
    localparam int CFG_D_W = 16;  // widest register

    localparam int MAX_LEVEL_DEF  = 7;
    localparam int INDEX_BITS_DEF = 16;

    localparam logic [VTX_W-1:0]   ROOT_APEX_RST  = 16'd72;
    localparam logic [VTX_W-1:0]   ROOT_LEFT_RST  = 16'd0;
    localparam logic [VTX_W-1:0]   ROOT_RIGHT_RST = 16'd80;
    localparam logic [LEVEL_W-1:0] TREE_DEPTH_RST = 3'd7;

    typedef logic [VTX_W-1:0] t_vtx;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_ABOVE = 2'd1,
        ERR_ZERO  = 2'd2
    } t_err;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_ROOT_APEX  = 2'd0,
        CFG_ROOT_LEFT  = 2'd1,
        CFG_ROOT_RIGHT = 2'd2,
        CFG_TREE_DEPTH = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // sequencer -> bisection unit
    typedef struct packed {
        logic load;      // take root triangle
        logic advance;   // descend one level
        logic go_right;  // pick right child on advance
    } t_step_ctl;

endpackage

`default_nettype wire

/* rtl/core/tbig_ifs.sv */
// Valid/ready channel interfaces: request beat and triangle result beat.
// Depends on tbig_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbig_req_if import tbig_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] requested_level;

    modport source (output valid, output requested_level, input ready);
    modport sink   (input valid, input requested_level, output ready);
endinterface

interface tbig_tri_if import tbig_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] apex_vertex;
    logic [VTX_W-1:0] left_vertex;
    logic [VTX_W-1:0] right_vertex;
    logic [ERR_W-1:0] error_code;
    logic             last_triangle;

    modport source (output valid, output apex_vertex, output left_vertex,
                    output right_vertex, output error_code, output last_triangle,
                    input ready);
    modport sink   (input valid, input apex_vertex, input left_vertex,
                    input right_vertex, input error_code, input last_triangle,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/tbig_bisect_unit.sv */
// Shared bisection unit: holds the working triangle, loads the root and
// steps to the left or right child (floor midpoint of the hypotenuse).
// Depends on tbig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbig_bisect_unit import tbig_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire t_step_ctl             i_ctl,
    input  wire logic [INDEX_BITS-1:0] i_root_apex,
    input  wire logic [INDEX_BITS-1:0] i_root_left,
    input  wire logic [INDEX_BITS-1:0] i_root_right,
    output logic      [INDEX_BITS-1:0] o_apex,
    output logic      [INDEX_BITS-1:0] o_left,
    output logic      [INDEX_BITS-1:0] o_right
);

    logic [INDEX_BITS-1:0] r_apex, r_left, r_right;
    logic [INDEX_BITS-1:0] n_apex, n_left, n_right;
    logic [INDEX_BITS:0]   sum;
    logic [INDEX_BITS-1:0] mid;

    // one-bit-wider sum, so the halving never drops a carry
    assign sum = {1'b0, r_left} + {1'b0, r_right};
    assign mid = sum[INDEX_BITS:1];

    always_comb begin
        n_apex  = r_apex;
        n_left  = r_left;
        n_right = r_right;
        if (i_ctl.load) begin
            n_apex  = i_root_apex;
            n_left  = i_root_left;
            n_right = i_root_right;
        end else if (i_ctl.advance) begin
            n_apex = mid;
            if (i_ctl.go_right) begin
                n_left  = r_right;
                n_right = r_apex;
            end else begin
                n_left  = r_apex;
                n_right = r_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_apex  <= n_apex;
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_apex  = r_apex;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

`default_nettype wire

/* rtl/core/triangle_bisection_index_generator.sv */
// A level-L request walks the path to each of its triangles in turn, from the
// root through the shared bisection unit, and emits each triangle when its
// walk ends; a held result beat holds the walk. Error requests give one beat.
// One request at a time. Reset (synchronous, active low) idles the sequencer
// and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_bisection_index_generator_assert.svh"

// Top level: config registers, sequencer, output register.
// Depends on tbig_pkg, tbig_ifs, tbig_bisect_unit.
module triangle_bisection_index_generator import tbig_pkg::*; #(
    parameter int MAX_LEVEL  = MAX_LEVEL_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_A_W-1:0] i_cfg_idx,
    input  wire logic [CFG_D_W-1:0] i_cfg_data,
    tbig_req_if.sink                i_req,
    tbig_tri_if.source              o_tri
);

    // path index width: one bit per walk step below the root
    localparam int K_W = (MAX_LEVEL > 1) ? MAX_LEVEL - 1 : 1;

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [K_W-1:0]        t_k;

    // ---------------- configuration registers ----------------
    t_vtx               r_root_apex, r_root_left, r_root_right;
    logic [LEVEL_W-1:0] r_tree_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_apex  <= ROOT_APEX_RST;
            r_root_left  <= ROOT_LEFT_RST;
            r_root_right <= ROOT_RIGHT_RST;
            r_tree_depth <= TREE_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_ROOT_APEX:  r_root_apex  <= i_cfg_data;
                CFG_ROOT_LEFT:  r_root_left  <= i_cfg_data;
                CFG_ROOT_RIGHT: r_root_right <= i_cfg_data;
                CFG_TREE_DEPTH: r_tree_depth <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    logic [LEVEL_W-1:0] eff_depth;
    logic [LEVEL_W-1:0] req_level;
    logic [LEVEL_W-1:0] req_lm1;
    logic [7:0]         req_count_m1;
    t_err               req_err;

    assign req_level = i_req.requested_level;
    // depth clipped to what the path counter can hold
    assign eff_depth = (r_tree_depth > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                            : r_tree_depth;

    always_comb begin
        if (req_level > eff_depth) begin
            req_err = ERR_ABOVE;
        end else if (req_level == '0) begin
            req_err = ERR_ZERO;
        end else begin
            req_err = ERR_NONE;
        end
    end

    // errors walk zero steps and emit a single beat
    assign req_lm1      = (req_err == ERR_NONE) ? LEVEL_W'(req_level - 3'd1) : '0;
    assign req_count_m1 = (8'd1 << req_lm1) - 8'd1;

    // ---------------- sequencer ----------------
    t_state             r_state, n_state;
    t_err               r_err, n_err;
    t_k                 r_k, n_k;           // triangle index within the level
    t_k                 r_kmax, n_kmax;     // index of the last triangle
    logic [LEVEL_W-1:0] r_lm1, n_lm1;       // walk length per triangle
    logic [LEVEL_W-1:0] r_steps, n_steps;   // walk steps still to go
    logic               r_out_valid, n_out_valid;
    t_vtx               r_out_apex, r_out_left, r_out_right;
    t_err               r_out_err;
    logic               r_out_last;

    t_step_ctl          step_ctl;
    t_idx               cur_apex, cur_left, cur_right;
    t_k                 k_shifted;
    logic               req_fire;
    logic               out_free;
    logic               emit;
    logic               emit_last;

    assign req_fire  = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_tri.ready;
    // path bits are taken MSB first: remaining steps s selects k bit s-1
    assign k_shifted = r_k >> LEVEL_W'(r_steps - 3'd1);
    assign emit_last = (r_k == r_kmax);

    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_k         = r_k;
        n_kmax      = r_kmax;
        n_lm1       = r_lm1;
        n_steps     = r_steps;
        step_ctl    = '0;
        emit        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_err         = req_err;
                    n_lm1         = req_lm1;
                    n_steps       = req_lm1;
                    n_k           = '0;
                    n_kmax        = K_W'(req_count_m1);
                    step_ctl.load = 1'b1;
                    n_state       = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_steps != '0) begin
                    step_ctl.advance  = 1'b1;
                    step_ctl.go_right = k_shifted[0];
                    n_steps           = LEVEL_W'(r_steps - 3'd1);
                end else if (out_free) begin
                    emit = 1'b1;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k           = K_W'(r_k + 1'b1);
                        n_steps       = r_lm1;
                        step_ctl.load = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_tri.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_err       <= ERR_NONE;
            r_k         <= '0;
            r_kmax      <= '0;
            r_lm1       <= '0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_err       <= n_err;
            r_k         <= n_k;
            r_kmax      <= n_kmax;
            r_lm1       <= n_lm1;
            r_steps     <= n_steps;
        end
    end

    // output register: payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_err == ERR_NONE) begin
                r_out_apex  <= t_vtx'(cur_apex);
                r_out_left  <= t_vtx'(cur_left);
                r_out_right <= t_vtx'(cur_right);
            end else begin
                r_out_apex  <= '0;
                r_out_left  <= '0;
                r_out_right <= '0;
            end
            r_out_err  <= r_err;
            r_out_last <= emit_last;
        end
    end

    // ---------------- shared bisection unit ----------------
    tbig_bisect_unit #(
        .INDEX_BITS (INDEX_BITS)
    ) u_bisect (
        .i_clk        (i_clk),
        .i_ctl        (step_ctl),
        .i_root_apex  (t_idx'(r_root_apex)),
        .i_root_left  (t_idx'(r_root_left)),
        .i_root_right (t_idx'(r_root_right)),
        .o_apex       (cur_apex),
        .o_left       (cur_left),
        .o_right      (cur_right)
    );

    // ---------------- ports ----------------
    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_tri.valid         = r_out_valid;
    assign o_tri.apex_vertex   = r_out_apex;
    assign o_tri.left_vertex   = r_out_left;
    assign o_tri.right_vertex  = r_out_right;
    assign o_tri.error_code    = r_out_err;
    assign o_tri.last_triangle = r_out_last;

    // ---------------- checks ----------------
    `TBIG_ASSERT_NXT(a_req_starts_walk, i_clk, i_rst_n, req_fire, r_state == ST_WALK)
    `TBIG_ASSERT_IMP(a_k_in_range, i_clk, i_rst_n, r_state == ST_WALK, r_k <= r_kmax)
    `TBIG_ASSERT_NXT(a_last_ends_req, i_clk, i_rst_n, emit && emit_last,
                     r_state == ST_IDLE && r_out_last)
    `TBIG_ASSERT_IMP(a_err_beat_clean, i_clk, i_rst_n,
                     o_tri.valid && r_out_err != ERR_NONE,
                     r_out_last && {r_out_apex, r_out_left, r_out_right} == '0)
    `TBIG_ASSERT_IMP(a_err_single, i_clk, i_rst_n, r_state == ST_WALK && r_err != ERR_NONE,
                     r_kmax == '0 && r_steps == '0)

endmodule

`default_nettype wire
